>>> design/ile_pkg.sv
// ile_pkg: shared types and constants for the indexed list engine
// action, status and cell operation codes, field widths and parameter defaults
// no dependencies
package ile_pkg;

    localparam int CapacityDefault   = 64;
    localparam int ValueWidthDefault = 32;
    localparam int MaxResults        = 64;

    localparam int ActionW = 3;
    localparam int IndexW  = 6;
    localparam int DataW   = 32;
    localparam int StatusW = 2;

    typedef enum logic [ActionW-1:0] {
        ACT_READ   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_DUMP   = 3'd4
    } action_t;

    typedef enum logic [StatusW-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // what every cell of the chain does with its stored value
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_WRITE_AT,
        OP_PULL_FROM,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

endpackage

>>> design/ile_if.sv
// ile_req_if, ile_rsp_if: valid/ready channels of the indexed list engine
// depends on ile_pkg for the field widths
interface ile_req_if;
    logic                              valid;
    logic                              ready;
    logic [ile_pkg::ActionW-1:0]       action;
    logic [ile_pkg::IndexW-1:0]        index;
    logic signed [ile_pkg::DataW-1:0]  value;

    modport source (output valid, action, index, value, input ready);
    modport sink   (input valid, action, index, value, output ready);
endinterface

interface ile_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [ile_pkg::DataW-1:0]  data;
    logic [ile_pkg::StatusW-1:0]       status;
    logic                              last;

    modport source (output valid, data, status, last, input ready);
    modport sink   (input valid, data, status, last, output ready);
endinterface

>>> design/ile_cell.sv
// ile_cell: one list position of the chain, holds one stored value
// takes its next value from its left or right neighbor, the head or the write bus
// depends on ile_pkg for the cell operation codes
module ile_cell #(
    parameter int VALUE_WIDTH = ile_pkg::ValueWidthDefault,
    parameter int COUNT_W     = 7,
    parameter int IDX         = 0
) (
    input  logic                   clk,
    input  ile_pkg::cell_op_t      op,
    input  logic [COUNT_W-1:0]     pos,
    input  logic [VALUE_WIDTH-1:0] wdata,
    input  logic [VALUE_WIDTH-1:0] left,
    input  logic [VALUE_WIDTH-1:0] right,
    input  logic [VALUE_WIDTH-1:0] head,
    output logic [VALUE_WIDTH-1:0] q
);

    localparam logic [COUNT_W-1:0] MyIdx = COUNT_W'(IDX);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            ile_pkg::OP_HOLD:
            begin
                data_next = data_reg;
            end
            ile_pkg::OP_PUSH_FRONT:
            begin
                data_next = (IDX == 0) ? wdata : left;
            end
            ile_pkg::OP_WRITE_AT:
            begin
                if (MyIdx == pos)
                begin
                    data_next = wdata;
                end
            end
            ile_pkg::OP_PULL_FROM:
            begin
                if (MyIdx >= pos)
                begin
                    data_next = right;
                end
            end
            ile_pkg::OP_ROTATE:
            begin
                // pos is the last occupied place, which takes the head
                if (MyIdx < pos)
                begin
                    data_next = right;
                end
                else if (MyIdx == pos)
                begin
                    data_next = head;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

>>> design/indexed_list_engine.sv
// indexed_list_engine: ordered list of signed values kept in a chain of cells
// insert, append, remove and misses answer in the cycle after acceptance
// read and dump rotate the chain once around, one place per cycle while no result waits
// on the response; the next transaction is taken after the last rotation
// rst_n clears the entry count, the state and the response valid; cell contents are not reset
// depends on ile_pkg, ile_if and ile_cell
module indexed_list_engine #(
    parameter int CAPACITY    = ile_pkg::CapacityDefault,
    parameter int VALUE_WIDTH = ile_pkg::ValueWidthDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    ile_req_if.sink    req,
    ile_rsp_if.source  rsp
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam logic [COUNT_W-1:0] CapCount = COUNT_W'(CAPACITY);

    ile_pkg::state_t state_reg;
    ile_pkg::state_t state_next;

    logic [COUNT_W-1:0]               count_reg;
    logic [COUNT_W-1:0]               count_next;
    logic [IDX_W-1:0]                 step_reg;
    logic [IDX_W-1:0]                 step_next;
    logic                             dump_reg;
    logic                             dump_next;
    logic [ile_pkg::IndexW-1:0]       idx_reg;
    logic [ile_pkg::IndexW-1:0]       idx_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [ile_pkg::DataW-1:0]        out_data_reg;
    logic [ile_pkg::DataW-1:0]        out_data_next;
    ile_pkg::status_t                 out_status_reg;
    ile_pkg::status_t                 out_status_next;
    logic                             out_last_reg;
    logic                             out_last_next;

    ile_pkg::cell_op_t                cell_op;
    logic [COUNT_W-1:0]               cell_pos;
    logic [VALUE_WIDTH-1:0]           val_store;
    logic [VALUE_WIDTH-1:0]           cell_q [CAPACITY];
    logic [ile_pkg::DataW-1:0]        head_low;

    logic                             out_free;
    logic                             accept;
    logic                             pos_hit;
    logic                             is_full;
    logic                             walk_emit;
    logic                             walk_adv;
    logic                             walk_end;
    logic                             dump_last;
    logic [31:0]                      dump_lim;

    // sign-extend or truncate the 32-bit input to the stored width
    assign val_store = VALUE_WIDTH'(req.value);
    assign head_low  = ile_pkg::DataW'(cell_q[0]);

    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ile_pkg::S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign pos_hit = 32'(req.index) < 32'(count_reg);
    assign is_full = count_reg == CapCount;

    // a dump gives at most MaxResults results
    assign dump_lim  = (32'(count_reg) > 32'(ile_pkg::MaxResults)) ?
                       32'(ile_pkg::MaxResults) : 32'(count_reg);
    assign dump_last = 32'(step_reg) == dump_lim - 32'd1;
    assign walk_emit = dump_reg ? (32'(step_reg) < 32'(ile_pkg::MaxResults))
                                : (32'(step_reg) == 32'(idx_reg));
    assign walk_adv  = !walk_emit || out_free;
    assign walk_end  = 32'(step_reg) == 32'(count_reg) - 32'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ile_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((ile_pkg::action_t'(req.action) == ile_pkg::ACT_READ && pos_hit) ||
                        (ile_pkg::action_t'(req.action) == ile_pkg::ACT_DUMP &&
                         count_reg != '0))
                    begin
                        state_next = ile_pkg::S_WALK;
                    end
                end
            end
            ile_pkg::S_WALK:
            begin
                if (walk_adv && walk_end)
                begin
                    state_next = ile_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ile_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and response control
    always_comb
    begin
        count_next      = count_reg;
        step_next       = step_reg;
        dump_next       = dump_reg;
        idx_next        = idx_reg;
        cell_op         = ile_pkg::OP_HOLD;
        cell_pos        = '0;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ile_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    step_next       = '0;
                    idx_next        = req.index;
                    dump_next       = ile_pkg::action_t'(req.action) == ile_pkg::ACT_DUMP;
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_status_next = ile_pkg::ST_MISS;
                    out_last_next   = 1'b1;
                    case (ile_pkg::action_t'(req.action))
                        ile_pkg::ACT_READ:
                        begin
                            // a hit answers during the walk
                            out_valid_next = !pos_hit;
                        end
                        ile_pkg::ACT_INSERT:
                        begin
                            if (is_full)
                            begin
                                out_status_next = ile_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_op         = ile_pkg::OP_PUSH_FRONT;
                                count_next      = count_reg + 1'b1;
                                out_status_next = ile_pkg::ST_DONE;
                            end
                        end
                        ile_pkg::ACT_APPEND:
                        begin
                            if (is_full)
                            begin
                                out_status_next = ile_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_op         = ile_pkg::OP_WRITE_AT;
                                cell_pos        = count_reg;
                                count_next      = count_reg + 1'b1;
                                out_status_next = ile_pkg::ST_DONE;
                            end
                        end
                        ile_pkg::ACT_REMOVE:
                        begin
                            if (pos_hit)
                            begin
                                cell_op         = ile_pkg::OP_PULL_FROM;
                                cell_pos        = COUNT_W'(req.index);
                                count_next      = count_reg - 1'b1;
                                out_status_next = ile_pkg::ST_DONE;
                            end
                        end
                        ile_pkg::ACT_DUMP:
                        begin
                            out_valid_next = count_reg == '0;
                        end
                        default:
                        begin
                            out_status_next = ile_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            ile_pkg::S_WALK:
            begin
                // the head cell holds the entry at position step_reg
                if (walk_adv)
                begin
                    cell_op   = ile_pkg::OP_ROTATE;
                    cell_pos  = count_reg - 1'b1;
                    step_next = step_reg + 1'b1;
                    if (walk_emit)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = head_low;
                        out_status_next = ile_pkg::ST_DONE;
                        out_last_next   = dump_reg ? dump_last : 1'b1;
                    end
                end
            end
            default:
            begin
                cell_op = ile_pkg::OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ile_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        dump_reg       <= dump_next;
        idx_reg        <= idx_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] left_val;
            logic [VALUE_WIDTH-1:0] right_val;

            if (gi == 0)
            begin : g_first
                assign left_val = '0;
            end
            else
            begin : g_mid_l
                assign left_val = cell_q[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_val = '0;
            end
            else
            begin : g_mid_r
                assign right_val = cell_q[gi+1];
            end

            ile_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .COUNT_W     (COUNT_W),
                .IDX         (gi)
            ) u_cell (
                .clk   (clk),
                .op    (cell_op),
                .pos   (cell_pos),
                .wdata (val_store),
                .left  (left_val),
                .right (right_val),
                .head  (cell_q[0]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.status = out_status_reg;
    assign rsp.last   = out_last_reg;

endmodule
